// ===== rtl/core/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants of the scanline stripe shader
// Holds coordinate sizing, register codes and reset values, the pixel and
// band types, and the sizing of the pipelined band divider.
// ----------------------------------------------------------------------------
package ssh_pkg;

    // Coordinate sizing: ports are 12 bits, only the low COORD_WIDTH count
    localparam int POS_WIDTH   = 12;
    localparam int COORD_WIDTH = 12;

    // Divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (COORD_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD    = DIV_STAGES * DIV_STEPS;
    localparam logic [DIV_PAD-1:0] COORD_MASK = DIV_PAD'((1 << COORD_WIDTH) - 1);

    // Register field widths
    localparam int HEIGHT_W  = 8;
    localparam int LEVEL_W   = 12;
    localparam int OPACITY_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Shader product width: covers c*1024 + 255*2047 + 512 with a sign bit
    localparam int PROD_W = 22;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIPE_HEIGHT = 3'd0,
        CFG_DIRECTION     = 3'd1,
        CFG_LEVEL_EVEN    = 3'd2,
        CFG_OPACITY_EVEN  = 3'd3,
        CFG_LEVEL_ODD     = 3'd4,
        CFG_OPACITY_ODD   = 3'd5
    } t_cfg_reg;

    // Reset values
    localparam logic [HEIGHT_W-1:0]  RST_STRIPE_HEIGHT = 8'd3;
    localparam logic                 RST_DIRECTION     = 1'b0;
    localparam logic [LEVEL_W-1:0]   RST_LEVEL_EVEN    = 12'hE00;  // -512
    localparam logic [OPACITY_W-1:0] RST_OPACITY_EVEN  = 11'd512;
    localparam logic [LEVEL_W-1:0]   RST_LEVEL_ODD     = 12'h000;
    localparam logic [OPACITY_W-1:0] RST_OPACITY_ODD   = 11'd1024;

    // One ARGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    // Shading of one band: level is signed 1024ths, opacity unsigned 1024ths
    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [OPACITY_W-1:0] opacity;
    } t_band;

endpackage

// ===== rtl/core/ssh_divide.sv =====
// ----------------------------------------------------------------------------
// ssh_divide: pipelined band index divider
// Restoring division of the coordinate by the stripe height, a few quotient
// bits per stage; only the parity of the quotient leaves the pipeline.
// ----------------------------------------------------------------------------
module ssh_divide (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [ssh_pkg::DIV_PAD-1:0]         i_coord,
    input  ssh_pkg::t_pixel                     i_pix,
    input  logic [ssh_pkg::HEIGHT_W-1:0]        i_height,
    output logic                                o_valid,
    output logic                                o_odd,
    output ssh_pkg::t_pixel                     o_pix
);

    // Stage inputs: index 0 is the module input, index s+1 the register of stage s
    logic                               stg_valid [0:ssh_pkg::DIV_STAGES];
    logic [ssh_pkg::DIV_PAD-1:0]        stg_num   [0:ssh_pkg::DIV_STAGES];
    logic [ssh_pkg::HEIGHT_W-1:0]       stg_rem   [0:ssh_pkg::DIV_STAGES];
    logic                               stg_q     [0:ssh_pkg::DIV_STAGES];
    ssh_pkg::t_pixel                    stg_pix   [0:ssh_pkg::DIV_STAGES];

    assign stg_valid[0] = i_valid;
    assign stg_num[0]   = i_coord;
    assign stg_rem[0]   = '0;
    assign stg_q[0]     = 1'b0;
    assign stg_pix[0]   = i_pix;

    for (genvar s = 0; s < ssh_pkg::DIV_STAGES; s++) begin : g_stage
        logic                           r_valid;
        logic [ssh_pkg::DIV_PAD-1:0]    r_num;
        logic [ssh_pkg::HEIGHT_W-1:0]   r_rem;
        logic                           r_q;
        ssh_pkg::t_pixel                r_pix;
        logic [ssh_pkg::DIV_PAD-1:0]    n_num;
        logic [ssh_pkg::HEIGHT_W-1:0]   n_rem;
        logic                           n_q;

        // Resolve the next quotient bits, most significant first
        always_comb begin
            logic [ssh_pkg::HEIGHT_W:0] trial;
            n_rem = stg_rem[s];
            n_q   = stg_q[s];
            trial = '0;
            for (int k = 0; k < ssh_pkg::DIV_STEPS; k++) begin
                trial = {n_rem, stg_num[s][ssh_pkg::DIV_PAD-1-k]};
                if (trial >= {1'b0, i_height}) begin
                    n_q   = 1'b1;
                    trial = trial - {1'b0, i_height};
                end else begin
                    n_q   = 1'b0;
                end
                n_rem = trial[ssh_pkg::HEIGHT_W-1:0];
            end
            n_num = stg_num[s] << ssh_pkg::DIV_STEPS;
        end

        // Advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= stg_valid[s];
            end
        end

        // Advance the payload
        always_ff @(posedge i_clk) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_q   <= n_q;
            r_pix <= stg_pix[s];
        end

        assign stg_valid[s+1] = r_valid;
        assign stg_num[s+1]   = r_num;
        assign stg_rem[s+1]   = r_rem;
        assign stg_q[s+1]     = r_q;
        assign stg_pix[s+1]   = r_pix;
    end

    assign o_valid = stg_valid[ssh_pkg::DIV_STAGES];
    assign o_odd   = stg_q[ssh_pkg::DIV_STAGES];
    assign o_pix   = stg_pix[ssh_pkg::DIV_STAGES];

endmodule

// ===== rtl/core/ssh_shade.sv =====
// ----------------------------------------------------------------------------
// ssh_shade: two-stage channel shader
// Stage one picks the band and forms one product per channel; stage two
// adds the bias, rounds, clamps and applies the zero level and zero opacity
// cases into the output registers.
// ----------------------------------------------------------------------------
module ssh_shade (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_odd,
    input  ssh_pkg::t_pixel i_pix,
    input  ssh_pkg::t_band  i_band_even,
    input  ssh_pkg::t_band  i_band_odd,
    output logic            o_valid,
    output ssh_pkg::t_pixel o_pix
);

    ssh_pkg::t_band                     sel_band;
    logic                               lv_pos;
    logic                               lv_zero;
    logic signed [12:0]                 mul_b;
    logic [7:0]                         chan     [0:2];
    logic signed [ssh_pkg::PROD_W-1:0]  n_prod   [0:2];
    logic [17:0]                        n_aprod;

    // Stage one registers
    logic                               r_valid_a;
    logic signed [ssh_pkg::PROD_W-1:0]  r_prod   [0:2];
    logic [7:0]                         r_chan   [0:2];
    logic [17:0]                        r_aprod;
    logic [7:0]                         r_alpha;
    logic                               r_lv_pos;
    logic                               r_lv_zero;
    logic                               r_op_zero;
    logic                               r_op_full;

    // Output stage
    logic                               r_valid;
    ssh_pkg::t_pixel                    r_pix;
    logic [7:0]                         n_res    [0:2];
    logic [17:0]                        n_asum;
    ssh_pkg::t_pixel                    n_pix;

    // Select band, form the per-channel products
    always_comb begin
        sel_band = i_odd ? i_band_odd : i_band_even;
        lv_zero  = (sel_band.level == '0);
        lv_pos   = !sel_band.level[ssh_pkg::LEVEL_W-1] && !lv_zero;
        // toward white: (255-c)*level; toward black: c*(1024+level)
        if (lv_pos) begin
            mul_b = $signed({sel_band.level[ssh_pkg::LEVEL_W-1], sel_band.level});
        end else begin
            mul_b = $signed(13'd1024)
                  + $signed({sel_band.level[ssh_pkg::LEVEL_W-1], sel_band.level});
        end
        chan[0] = i_pix.red;
        chan[1] = i_pix.green;
        chan[2] = i_pix.blue;
        for (int i = 0; i < 3; i++) begin
            if (lv_pos) begin
                n_prod[i] = $signed({1'b0, 8'd255 - chan[i]}) * mul_b;
            end else begin
                n_prod[i] = $signed({1'b0, chan[i]}) * mul_b;
            end
        end
        n_aprod = i_pix.alpha * sel_band.opacity[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= n_prod[i];
            r_chan[i] <= chan[i];
        end
        r_aprod   <= n_aprod;
        r_alpha   <= i_pix.alpha;
        r_lv_pos  <= lv_pos;
        r_lv_zero <= lv_zero;
        r_op_zero <= (sel_band.opacity == '0);
        r_op_full <= sel_band.opacity[ssh_pkg::OPACITY_W-1];
    end

    // Add bias, round half up, clamp to 0..255
    always_comb begin
        logic signed [ssh_pkg::PROD_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            sum = r_prod[i] + $signed(ssh_pkg::PROD_W'(10'd512));
            if (r_lv_pos) begin
                sum = sum + $signed(ssh_pkg::PROD_W'({r_chan[i], 10'b0}));
            end
            if (r_lv_zero) begin
                n_res[i] = r_chan[i];
            end else if (sum[ssh_pkg::PROD_W-1]) begin
                n_res[i] = 8'd0;
            end else if (|sum[ssh_pkg::PROD_W-2:18]) begin
                n_res[i] = 8'd255;
            end else begin
                n_res[i] = sum[17:10];
            end
        end
        n_asum = r_aprod + 18'd512;
        if (r_op_zero) begin
            n_pix = '0;
        end else begin
            n_pix.red   = n_res[0];
            n_pix.green = n_res[1];
            n_pix.blue  = n_res[2];
            n_pix.alpha = r_op_full ? r_alpha : n_asum[17:10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ===== rtl/core/scanline_stripe_shade.sv =====
// ----------------------------------------------------------------------------
// scanline_stripe_shade: scanline overlay for 8-bit ARGB pixels
// Darkens or lightens pixels in alternating bands of rows or columns and
// scales their alpha, with band parameters from a register write port.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request with i_start high together with the pixel coordinates
//   and channels. o_busy stays low: a request is taken on every cycle that
//   i_start is high, back to back without gaps.
//   Each result appears on o_out_* for exactly one cycle with o_valid high,
//   after its request has passed the input register, four divider stages and
//   two shading stages. One result leaves per cycle at full rate.
//   The band index comes from a restoring divide of the coordinate by the
//   stripe height, three quotient bits per stage; its depth sets the latency.
//   Results leave in request order. The receiver has no hold-off: it must
//   take each result in the cycle it is shown. Registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data, one per cycle; the user must write
//   them only while no request is in flight, which the block does not
//   enforce. Unknown indexes are ignored. Reset (i_rst_n low, synchronous)
//   drops every request in flight and loads the register defaults: height 3,
//   row bands, even level -512 and opacity 512, odd level 0 and opacity 1024.
// ----------------------------------------------------------------------------
module scanline_stripe_shade (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [ssh_pkg::POS_WIDTH-1:0]       i_pos_x,
    input  logic [ssh_pkg::POS_WIDTH-1:0]       i_pos_y,
    input  logic [7:0]                          i_in_red,
    input  logic [7:0]                          i_in_green,
    input  logic [7:0]                          i_in_blue,
    input  logic [7:0]                          i_in_alpha,
    input  logic                                i_cfg_we,
    input  logic [ssh_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssh_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [7:0]                          o_out_red,
    output logic [7:0]                          o_out_green,
    output logic [7:0]                          o_out_blue,
    output logic [7:0]                          o_out_alpha
);

    // Configuration registers
    logic [ssh_pkg::HEIGHT_W-1:0]   r_stripe_height;
    logic                           r_direction;
    ssh_pkg::t_band                 r_band_even;
    ssh_pkg::t_band                 r_band_odd;
    logic [ssh_pkg::HEIGHT_W-1:0]   height;

    // Input stage
    logic                           accept;
    logic                           r_in_valid;
    logic [ssh_pkg::DIV_PAD-1:0]    r_coord;
    ssh_pkg::t_pixel                r_pix;
    logic [ssh_pkg::DIV_PAD-1:0]    n_coord;
    ssh_pkg::t_pixel                n_pix;

    // Divider to shader
    logic                           div_valid;
    logic                           div_odd;
    ssh_pkg::t_pixel                div_pix;
    logic                           shd_valid;
    ssh_pkg::t_pixel                shd_pix;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stripe_height     <= ssh_pkg::RST_STRIPE_HEIGHT;
            r_direction         <= ssh_pkg::RST_DIRECTION;
            r_band_even.level   <= ssh_pkg::RST_LEVEL_EVEN;
            r_band_even.opacity <= ssh_pkg::RST_OPACITY_EVEN;
            r_band_odd.level    <= ssh_pkg::RST_LEVEL_ODD;
            r_band_odd.opacity  <= ssh_pkg::RST_OPACITY_ODD;
        end else if (i_cfg_we) begin
            unique case (ssh_pkg::t_cfg_reg'(i_cfg_idx))
                ssh_pkg::CFG_STRIPE_HEIGHT: begin
                    r_stripe_height <= i_cfg_data[ssh_pkg::HEIGHT_W-1:0];
                end
                ssh_pkg::CFG_DIRECTION: begin
                    r_direction <= i_cfg_data[0];
                end
                ssh_pkg::CFG_LEVEL_EVEN: begin
                    r_band_even.level <= i_cfg_data[ssh_pkg::LEVEL_W-1:0];
                end
                ssh_pkg::CFG_OPACITY_EVEN: begin
                    r_band_even.opacity <= i_cfg_data[ssh_pkg::OPACITY_W-1:0];
                end
                ssh_pkg::CFG_LEVEL_ODD: begin
                    r_band_odd.level <= i_cfg_data[ssh_pkg::LEVEL_W-1:0];
                end
                ssh_pkg::CFG_OPACITY_ODD: begin
                    r_band_odd.opacity <= i_cfg_data[ssh_pkg::OPACITY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero height acts as a height of one
    assign height = (r_stripe_height == '0) ? ssh_pkg::HEIGHT_W'(1) : r_stripe_height;

    // Select and mask the band coordinate
    always_comb begin
        if (r_direction) begin
            n_coord = ssh_pkg::DIV_PAD'(i_pos_x) & ssh_pkg::COORD_MASK;
        end else begin
            n_coord = ssh_pkg::DIV_PAD'(i_pos_y) & ssh_pkg::COORD_MASK;
        end
        n_pix.red   = i_in_red;
        n_pix.green = i_in_green;
        n_pix.blue  = i_in_blue;
        n_pix.alpha = i_in_alpha;
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= n_coord;
        r_pix   <= n_pix;
    end

    ssh_divide u_divide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_coord  (r_coord),
        .i_pix    (r_pix),
        .i_height (height),
        .o_valid  (div_valid),
        .o_odd    (div_odd),
        .o_pix    (div_pix)
    );

    ssh_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .i_odd       (div_odd),
        .i_pix       (div_pix),
        .i_band_even (r_band_even),
        .i_band_odd  (r_band_odd),
        .o_valid     (shd_valid),
        .o_pix       (shd_pix)
    );

    assign o_valid     = shd_valid;
    assign o_out_red   = shd_pix.red;
    assign o_out_green = shd_pix.green;
    assign o_out_blue  = shd_pix.blue;
    assign o_out_alpha = shd_pix.alpha;

endmodule

// ===== bench/scanline_stripe_shade_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanline_stripe_shade_test: self-checking bench for the scanline shader
// Drives pixel requests in random bursts, predicts each shaded pixel from a
// local copy of the band registers and compares every result in order.
// Directed cases cover band selection, extreme levels and opacities, zero
// opacity, zero level and zero stripe height. The random phases then reload
// the registers with random and extreme settings between streams.
// ----------------------------------------------------------------------------
module scanline_stripe_shade_test;

    localparam int PIPE_LATENCY     = 7;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PHASES    = 12;
    localparam int PIXELS_PER_PHASE = 158;
    localparam int FULL_SCALE       = 1024;
    localparam int REPORT_LIMIT     = 10;

    // Indexes that map to no register; writes to them must be ignored
    localparam logic [ssh_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [ssh_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_start    = 1'b0;
    logic                           o_busy;
    logic [ssh_pkg::POS_WIDTH-1:0]  i_pos_x    = '0;
    logic [ssh_pkg::POS_WIDTH-1:0]  i_pos_y    = '0;
    logic [7:0]                     i_in_red   = '0;
    logic [7:0]                     i_in_green = '0;
    logic [7:0]                     i_in_blue  = '0;
    logic [7:0]                     i_in_alpha = '0;
    logic                           i_cfg_we   = 1'b0;
    logic [ssh_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [ssh_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_valid;
    logic [7:0]                     o_out_red;
    logic [7:0]                     o_out_green;
    logic [7:0]                     o_out_blue;
    logic [7:0]                     o_out_alpha;

    // Local copy of the band registers
    logic [ssh_pkg::HEIGHT_W-1:0]         band_height;
    logic                                 band_dir;
    logic signed [ssh_pkg::LEVEL_W-1:0]   lvl_even;
    logic [ssh_pkg::OPACITY_W-1:0]        opa_even;
    logic signed [ssh_pkg::LEVEL_W-1:0]   lvl_odd;
    logic [ssh_pkg::OPACITY_W-1:0]        opa_odd;

    ssh_pkg::t_pixel pending_pixels[$];
    int              mismatches  = 0;
    int              idle_cycles = 0;

    scanline_stripe_shade DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    always #5 i_clk = ~i_clk;

    // Move one channel toward white (positive level) or black (negative level)
    function automatic logic [7:0] shift_channel(logic [7:0] c,
                                                 logic signed [ssh_pkg::LEVEL_W-1:0] lv);
        int num;
        if (lv == 0)
            return c;
        if (lv > 0)
            num = int'(c) * FULL_SCALE + (255 - int'(c)) * int'(lv) + FULL_SCALE / 2;
        else
            num = int'(c) * (FULL_SCALE + int'(lv)) + FULL_SCALE / 2;
        if (num < 0)
            return 8'd0;
        num = num / FULL_SCALE;
        return (num > 255) ? 8'd255 : 8'(num);
    endfunction

    // Shade one pixel with the band that its coordinate falls in
    function automatic ssh_pkg::t_pixel shade_pixel(logic [ssh_pkg::POS_WIDTH-1:0] x,
                                                    logic [ssh_pkg::POS_WIDTH-1:0] y,
                                                    logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b, logic [7:0] a);
        ssh_pkg::t_pixel                    px;
        int                                 coord;
        int                                 height;
        logic                               odd;
        logic signed [ssh_pkg::LEVEL_W-1:0] lv;
        logic [ssh_pkg::OPACITY_W-1:0]      op;
        coord  = int'(band_dir ? x : y) & ((1 << ssh_pkg::COORD_WIDTH) - 1);
        height = (band_height == 0) ? 1 : int'(band_height);
        odd    = ((coord / height) % 2) != 0;
        lv     = odd ? lvl_odd : lvl_even;
        op     = odd ? opa_odd : opa_even;
        if (op == 0)
            return '0;
        px.red   = shift_channel(r, lv);
        px.green = shift_channel(g, lv);
        px.blue  = shift_channel(b, lv);
        px.alpha = (op >= FULL_SCALE) ? a
                 : 8'((int'(a) * int'(op) + FULL_SCALE / 2) / FULL_SCALE);
        return px;
    endfunction

    task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Check each result, predict each accepted request, track register writes
    always @(posedge i_clk) begin : track_block
        ssh_pkg::t_pixel want;
        if (!i_rst_n) begin
            band_height = ssh_pkg::RST_STRIPE_HEIGHT;
            band_dir    = ssh_pkg::RST_DIRECTION;
            lvl_even    = ssh_pkg::RST_LEVEL_EVEN;
            opa_even    = ssh_pkg::RST_OPACITY_EVEN;
            lvl_odd     = ssh_pkg::RST_LEVEL_ODD;
            opa_odd     = ssh_pkg::RST_OPACITY_ODD;
        end else begin
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: %0d %0d %0d %0d",
                                 $realtime, o_out_red, o_out_green, o_out_blue, o_out_alpha);
                end else begin
                    want = pending_pixels.pop_front();
                    check_channel("red", want.red, o_out_red);
                    check_channel("green", want.green, o_out_green);
                    check_channel("blue", want.blue, o_out_blue);
                    check_channel("alpha", want.alpha, o_out_alpha);
                end
            end
            if (i_start && !o_busy)
                pending_pixels.push_back(shade_pixel(i_pos_x, i_pos_y, i_in_red,
                                                     i_in_green, i_in_blue, i_in_alpha));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssh_pkg::CFG_STRIPE_HEIGHT:
                        band_height = i_cfg_data[ssh_pkg::HEIGHT_W-1:0];
                    ssh_pkg::CFG_DIRECTION:
                        band_dir    = i_cfg_data[0];
                    ssh_pkg::CFG_LEVEL_EVEN:
                        lvl_even    = i_cfg_data[ssh_pkg::LEVEL_W-1:0];
                    ssh_pkg::CFG_OPACITY_EVEN:
                        opa_even    = i_cfg_data[ssh_pkg::OPACITY_W-1:0];
                    ssh_pkg::CFG_LEVEL_ODD:
                        lvl_odd     = i_cfg_data[ssh_pkg::LEVEL_W-1:0];
                    ssh_pkg::CFG_OPACITY_ODD:
                        opa_odd     = i_cfg_data[ssh_pkg::OPACITY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold one request until the block takes it
    task automatic send_pixel(logic [ssh_pkg::POS_WIDTH-1:0] x,
                              logic [ssh_pkg::POS_WIDTH-1:0] y,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        i_start    <= 1'b1;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drop start and wait until every pending result has come back
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [ssh_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Load all band registers once the pipeline is empty
    task automatic program_regs(logic [ssh_pkg::CFG_DATA_W-1:0] height,
                                logic [ssh_pkg::CFG_DATA_W-1:0] dir,
                                logic [ssh_pkg::CFG_DATA_W-1:0] lev_e,
                                logic [ssh_pkg::CFG_DATA_W-1:0] opa_e,
                                logic [ssh_pkg::CFG_DATA_W-1:0] lev_o,
                                logic [ssh_pkg::CFG_DATA_W-1:0] opa_o);
        drain();
        put_reg(ssh_pkg::CFG_STRIPE_HEIGHT, height);
        put_reg(ssh_pkg::CFG_DIRECTION, dir);
        put_reg(ssh_pkg::CFG_LEVEL_EVEN, lev_e);
        put_reg(IDX_UNMAPPED_LO, 12'($urandom));
        put_reg(ssh_pkg::CFG_OPACITY_EVEN, opa_e);
        put_reg(ssh_pkg::CFG_LEVEL_ODD, lev_o);
        put_reg(IDX_UNMAPPED_HI, 12'($urandom));
        put_reg(ssh_pkg::CFG_OPACITY_ODD, opa_o);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ssh_pkg::CFG_DATA_W-1:0] pick_height();
        logic [ssh_pkg::HEIGHT_W-1:0] h;
        case ($urandom_range(0, 5))
            0:       h = 8'd0;
            1:       h = 8'd1;
            2:       h = 8'd255;
            3:       h = 8'($urandom_range(1, 8));
            default: h = 8'($urandom_range(1, 255));
        endcase
        return {4'($urandom), h};
    endfunction

    function automatic logic [ssh_pkg::CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 12'h800;
            1:       return 12'hC00;
            2:       return 12'hFFF;
            3:       return 12'h000;
            4:       return 12'h001;
            5:       return 12'h400;
            6:       return 12'h7FF;
            default: return 12'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic logic [ssh_pkg::CFG_DATA_W-1:0] pick_opacity();
        logic [ssh_pkg::OPACITY_W-1:0] op;
        case ($urandom_range(0, 8))
            0:       op = 11'd0;
            1:       op = 11'd1;
            2:       op = 11'd1023;
            3:       op = 11'd1024;
            4:       op = 11'd2047;
            default: op = 11'($urandom_range(0, 1024));
        endcase
        return {1'($urandom), op};
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Stream random pixels; with gaps on, idle between bursts of random length
    task automatic run_random_pixels(int count, bit with_gaps);
        int burst;
        int gap;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
            send_pixel(12'($urandom), 12'($urandom), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel());
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (with_gaps && gap > 0) begin
                    i_start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 40);
            end
        end
    endtask

    // Reset defaults: row bands of 3, dark even band, clear odd band
    task automatic test_reset_values();
        send_pixel(12'hFFF, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(12'h000, 12'd3, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'h000, 12'd5, 8'd200, 8'd17, 8'd99, 8'd128);
        send_pixel(12'hAAA, 12'hFFF, 8'd1, 8'd254, 8'd128, 8'd77);
    endtask

    // Levels past full scale both ways, opacity above full scale
    task automatic test_level_extremes();
        program_regs(12'h001, 12'h000, 12'h7FF, 12'h7FF, 12'h800, 12'h3FF);
        send_pixel(12'h000, 12'h000, 8'd0, 8'd255, 8'd1, 8'd255);
        send_pixel(12'h000, 12'h001, 8'd0, 8'd255, 8'd1, 8'd255);
        send_pixel(12'h555, 12'hFFF, 8'd128, 8'd127, 8'd64, 8'd1);
        send_pixel(12'hFFF, 12'h002, 8'd255, 8'd0, 8'd255, 8'd0);
    endtask

    // Column bands of 255, full white and full black levels
    task automatic test_unit_levels();
        program_regs(12'h0FF, 12'h001, 12'h400, 12'h400, 12'hC00, 12'h001);
        send_pixel(12'd0, 12'hFFF, 8'd0, 8'd100, 8'd255, 8'd255);
        send_pixel(12'd254, 12'h000, 8'd37, 8'd200, 8'd3, 8'd128);
        send_pixel(12'd255, 12'h123, 8'd255, 8'd1, 8'd160, 8'd255);
        send_pixel(12'hFFF, 12'h800, 8'd90, 8'd91, 8'd92, 8'd200);
    endtask

    // Zero height acts as one, zero level keeps RGB, zero opacity blanks
    task automatic test_zero_cases();
        program_regs(12'hF00, 12'hFFF, 12'h000, 12'd700, 12'h005, 12'h800);
        send_pixel(12'd0, 12'd9, 8'd10, 8'd20, 8'd30, 8'd255);
        send_pixel(12'd1, 12'd9, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd2, 12'd0, 8'd255, 8'd0, 8'd128, 8'd1);
        send_pixel(12'd3, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // Random register settings, each followed by a random pixel stream
    task automatic test_random_shading();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_regs(pick_height(), {11'($urandom), 1'($urandom)}, pick_level(),
                         pick_opacity(), pick_level(), pick_opacity());
            run_random_pixels(PIXELS_PER_PHASE, (phase % 4) != 3);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_level_extremes();
        test_unit_levels();
        test_zero_cases();
        test_random_shading();
        drain();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
